// ----- rtl/bse_pkg.sv -----
package bse_pkg;

  localparam int OP_W     = 4;
  localparam int SET_W    = 3;
  localparam int BITNUM_W = 10;
  localparam int HIGH_W   = 11;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 4'd0,
    OP_CLEAR  = 4'd1,
    OP_TEST   = 4'd2,
    OP_HIGH   = 4'd3,
    OP_UNION  = 4'd4,
    OP_INTER  = 4'd5,
    OP_DIFF   = 4'd6,
    OP_ORANDN = 4'd7,
    OP_EMPTY  = 4'd8
  } op_t;

endpackage

// ----- rtl/bse_if.sv -----
interface bse_in_if import bse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SET_W-1:0]    dst_set;
  logic [SET_W-1:0]    src_a;
  logic [SET_W-1:0]    src_b;
  logic [SET_W-1:0]    src_c;
  logic [BITNUM_W-1:0] bit_number;

  modport source (output valid, operation, dst_set, src_a, src_b, src_c, bit_number,
                  input ready);
  modport sink   (input valid, operation, dst_set, src_a, src_b, src_c, bit_number,
                  output ready);
endinterface

interface bse_out_if import bse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              bit_value;
  logic [HIGH_W-1:0] highest_plus_one;
  logic              changed;

  modport source (output valid, status, bit_value, highest_plus_one, changed,
                  input ready);
  modport sink   (input valid, status, bit_value, highest_plus_one, changed,
                  output ready);
endinterface

// ----- rtl/bitset_store_engine_top.sv -----
// Set zero-fills any words between the used length and the target word; clear trims the
// used length past zero top words; highest bit shifts the top word until it is zero; set
// algebra walks every word of the set; unused codes go straight to the response.
// One item at a time; a result waiting at the output holds the block.
// Reset (synchronous, active low) empties every set; the word memory is not cleared.
module bitset_store_engine_top import bse_pkg::*; #(
  parameter int NUM_SETS      = 8,
  parameter int WORDS_PER_SET = 16,
  parameter int WORD_BITS     = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  bse_in_if.sink    in_chan,
  bse_out_if.source out_chan
);

  localparam int DEPTH = NUM_SETS * WORDS_PER_SET;
  localparam int AW    = $clog2(DEPTH);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  bse_seq #(
    .NUM_SETS      (NUM_SETS),
    .WORDS_PER_SET (WORDS_PER_SET),
    .WORD_BITS     (WORD_BITS),
    .AW            (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bse_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/bse_mem.sv -----
module bse_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 64,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bse_seq.sv -----
module bse_seq import bse_pkg::*; #(
  parameter int NUM_SETS      = 8,
  parameter int WORDS_PER_SET = 16,
  parameter int WORD_BITS     = 64,
  parameter int AW            = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bse_in_if.sink               in_chan,
  bse_out_if.source            out_chan,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [WORD_BITS-1:0] mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  logic [WORD_BITS-1:0] mem_rdata
);

  localparam int SW  = $clog2(NUM_SETS);
  localparam int LW  = $clog2(WORDS_PER_SET + 1);
  localparam int BPW = $clog2(WORD_BITS);
  localparam int unsigned CAP_BITS = WORDS_PER_SET * WORD_BITS;
  localparam int DIV_SH = 20;
  localparam int unsigned DIV_RECIP = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_LEN, S_DISP, S_ZERO, S_RMW_RD, S_RMW_WR, S_TRIM_RD,
    S_TRIM_CHK, S_HI_RD, S_HI_LOAD, S_HI_SCAN, S_ALG, S_ALG_WR, S_DONE
  } state_t;

  state_t state_r;
  logic [OP_W-1:0]      op_r;
  logic [SET_W-1:0]     d_r, a_r, b_r, c_r;
  logic [BITNUM_W-1:0]  rem_r, widx_r;
  logic [LW-1:0]        la_r, lb_r, lc_r, ld_r;
  logic [1:0]           k_r;
  logic [LW-1:0]        i_r;
  logic [LW-1:0]        newlen_r;
  logic [WORD_BITS-1:0] w_r, wa_r, wb_r, wc_r;
  logic [HIGH_W-1:0]    hi_r;
  logic                 status_r, bitv_r, chg_r;
  logic                 rd_vld_r, rd_gate_r;
  logic [1:0]           rd_slot_r;
  logic [LW-1:0]        len_r [NUM_SETS];

  logic                 out_valid_r, out_status_r, out_bitv_r, out_chg_r;
  logic [HIGH_W-1:0]    out_high_r;

  logic [SET_W-1:0]     k_set;
  logic                 k_set_ok;
  logic [LW-1:0]        k_len, len_rd;
  logic                 src_gate;
  logic [WORD_BITS-1:0] bmask, old_word, rd_word, alg_res;
  logic                 widx_in;
  logic [LW-1:0]        alg_len;
  logic [31:0]          div_prod;
  logic [BITNUM_W-1:0]  div_q, div_r;

  function automatic logic [AW-1:0] word_addr(input int unsigned s, input int unsigned idx);
    logic [31:0] full;
    full = 32'(s) * 32'(WORDS_PER_SET) + 32'(idx);
    return AW'(full);
  endfunction

  always_comb begin
    case (k_r)
      2'd0:    begin k_set = a_r; k_len = la_r; end
      2'd1:    begin k_set = b_r; k_len = lb_r; end
      2'd2:    begin k_set = c_r; k_len = lc_r; end
      default: begin k_set = d_r; k_len = ld_r; end
    endcase
  end

  assign k_set_ok = 32'(k_set) < 32'(NUM_SETS);
  assign len_rd   = k_set_ok ? len_r[SW'(k_set)] : '0;
  assign src_gate = k_set_ok && (32'(i_r) < 32'(k_len));
  assign bmask    = WORD_BITS'(1) << rem_r[BPW-1:0];
  assign widx_in  = 32'(widx_r) < 32'(ld_r);
  assign old_word = widx_in ? mem_rdata : '0;
  assign rd_word  = rd_gate_r ? mem_rdata : '0;

  // Word index by multiplying with a rounded-up reciprocal of the word width;
  // the shift is wide enough to be exact for every bit number.
  assign div_prod = 32'(rem_r) * 32'(DIV_RECIP);
  assign div_q    = BITNUM_W'(div_prod >> DIV_SH);
  assign div_r    = BITNUM_W'(32'(rem_r) - 32'(div_q) * 32'(WORD_BITS));

  // In the write step the destination word arrives straight from the memory.
  always_comb begin
    case (op_r)
      OP_UNION: alg_res = wa_r | wb_r;
      OP_INTER: alg_res = rd_word & wb_r;
      OP_DIFF:  alg_res = wa_r & ~wb_r;
      default:  alg_res = wa_r | (wb_r & ~wc_r);
    endcase
  end

  assign alg_len = (alg_res != '0) ? LW'(32'(i_r) + 32'd1) : newlen_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_addr(32'(d_r), 32'(widx_r));
    mem_wdata = '0;
    mem_raddr = word_addr(32'(d_r), 32'(widx_r));
    unique case (state_r)
      S_ZERO: begin
        mem_waddr = word_addr(32'(d_r), 32'(i_r));
        mem_we    = 32'(i_r) < 32'(widx_r);
      end
      S_RMW_WR: begin
        mem_we    = (op_r == OP_SET) || (op_r == OP_CLEAR);
        mem_wdata = (op_r == OP_SET) ? (old_word | bmask) : (old_word & ~bmask);
      end
      S_TRIM_RD: mem_raddr = word_addr(32'(d_r), 32'(i_r) - 32'd1);
      S_HI_RD:   mem_raddr = word_addr(32'(d_r), 32'(ld_r) - 32'd1);
      S_ALG:     mem_raddr = k_set_ok ? word_addr(32'(k_set), 32'(i_r)) : '0;
      S_ALG_WR: begin
        mem_we    = 1'b1;
        mem_waddr = word_addr(32'(d_r), 32'(i_r));
        mem_wdata = alg_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int s = 0; s < NUM_SETS; s++) begin
        len_r[s] <= '0;
      end
    end else begin
      if (out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r  <= (state_r == S_ALG);
      rd_gate_r <= src_gate;
      rd_slot_r <= k_r;
      if (rd_vld_r) begin
        case (rd_slot_r)
          2'd0:    wa_r <= rd_word;
          2'd1:    wb_r <= rd_word;
          2'd2:    wc_r <= rd_word;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r     <= in_chan.operation;
            d_r      <= in_chan.dst_set;
            a_r      <= in_chan.src_a;
            b_r      <= in_chan.src_b;
            c_r      <= in_chan.src_c;
            rem_r    <= in_chan.bit_number;
            widx_r   <= '0;
            k_r      <= '0;
            status_r <= 1'b0;
            bitv_r   <= 1'b0;
            chg_r    <= 1'b0;
            hi_r     <= '0;
            if (32'(in_chan.dst_set) >= 32'(NUM_SETS) || in_chan.operation > OP_EMPTY) begin
              state_r <= S_DONE;
            end else if (in_chan.operation <= OP_TEST) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_LEN;
            end
          end
        end
        S_DIV: begin
          widx_r  <= div_q;
          rem_r   <= div_r;
          state_r <= S_LEN;
        end
        S_LEN: begin
          case (k_r)
            2'd0:    la_r <= len_rd;
            2'd1:    lb_r <= len_rd;
            2'd2:    lc_r <= len_rd;
            default: ld_r <= len_rd;
          endcase
          k_r <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          i_r      <= '0;
          newlen_r <= '0;
          case (op_r)
            OP_SET: begin
              if (32'(widx_r) * 32'(WORD_BITS) + 32'(rem_r) >= CAP_BITS) begin
                status_r <= 1'b1;
                state_r  <= S_DONE;
              end else begin
                i_r     <= ld_r;
                state_r <= S_ZERO;
              end
            end
            OP_CLEAR: state_r <= widx_in ? S_RMW_RD : S_DONE;
            OP_TEST:  state_r <= S_RMW_RD;
            OP_HIGH:  state_r <= (ld_r == '0) ? S_DONE : S_HI_RD;
            OP_EMPTY: begin
              len_r[SW'(d_r)] <= '0;
              state_r         <= S_DONE;
            end
            default:  state_r <= S_ALG;
          endcase
        end
        S_ZERO: begin
          if (32'(i_r) < 32'(widx_r)) begin
            i_r <= i_r + 1'b1;
          end else begin
            state_r <= S_RMW_RD;
          end
        end
        S_RMW_RD: state_r <= S_RMW_WR;
        S_RMW_WR: begin
          case (op_r)
            OP_SET: begin
              if (!widx_in) begin
                len_r[SW'(d_r)] <= LW'(32'(widx_r) + 32'd1);
              end
              state_r <= S_DONE;
            end
            OP_CLEAR: begin
              i_r     <= ld_r;
              state_r <= S_TRIM_RD;
            end
            default: begin
              bitv_r  <= old_word[rem_r[BPW-1:0]];
              state_r <= S_DONE;
            end
          endcase
        end
        // Walk the used length down past zero top words.
        S_TRIM_RD: begin
          if (i_r == '0) begin
            len_r[SW'(d_r)] <= '0;
            state_r         <= S_DONE;
          end else begin
            state_r <= S_TRIM_CHK;
          end
        end
        S_TRIM_CHK: begin
          if (mem_rdata == '0) begin
            i_r     <= i_r - 1'b1;
            state_r <= S_TRIM_RD;
          end else begin
            len_r[SW'(d_r)] <= i_r;
            state_r         <= S_DONE;
          end
        end
        S_HI_RD: state_r <= S_HI_LOAD;
        S_HI_LOAD: begin
          w_r     <= mem_rdata;
          hi_r    <= HIGH_W'((32'(ld_r) - 32'd1) * 32'(WORD_BITS));
          state_r <= S_HI_SCAN;
        end
        S_HI_SCAN: begin
          if (w_r != '0) begin
            w_r  <= w_r >> 1;
            hi_r <= hi_r + 1'b1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_ALG: begin
          k_r <= k_r + 1'b1;
          if (k_r == 2'd3) begin
            state_r <= S_ALG_WR;
          end
        end
        S_ALG_WR: begin
          if (alg_res != rd_word) begin
            chg_r <= 1'b1;
          end
          newlen_r <= alg_len;
          if (32'(i_r) == 32'(WORDS_PER_SET) - 32'd1) begin
            len_r[SW'(d_r)] <= alg_len;
            state_r         <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_ALG;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_bitv_r   <= bitv_r;
            out_high_r   <= hi_r;
            out_chg_r    <= chg_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.bit_value        = out_bitv_r;
  assign out_chan.highest_plus_one = out_high_r;
  assign out_chan.changed          = out_chg_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");
  a_alg_wr_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALG_WR) |-> (rd_vld_r && rd_slot_r == 2'd3))
    else $error("destination word not in flight at algebra write");
  a_status_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r) |-> (op_r == OP_SET))
    else $error("capacity error on an operation other than set");
  a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished item did not reach the output register");
`endif

endmodule

// ----- tb/sv/bse_tb_pkg.sv -----
`timescale 1ns / 1ps
package bse_tb_pkg;
  import bse_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [SET_W-1:0]    dst_set;
    logic [SET_W-1:0]    src_a;
    logic [SET_W-1:0]    src_b;
    logic [SET_W-1:0]    src_c;
    logic [BITNUM_W-1:0] bit_number;
  } bse_req_t;

  typedef struct packed {
    logic              status;
    logic              bit_value;
    logic [HIGH_W-1:0] highest_plus_one;
    logic              changed;
  } bse_rsp_t;

  localparam int N_SETS = 8;
  localparam int N_WORDS = 16;
  localparam int W_BITS = 64;

  // Mirror of the set store that computes the expected response of each request.
  class bitset_scoreboard;
    logic [W_BITS-1:0] words[N_SETS][N_WORDS];
    int unsigned       lengths[N_SETS];
    bse_rsp_t          pending[$];
    int                errors;

    function new();
      foreach (lengths[s]) lengths[s] = 0;
      foreach (words[s, i]) words[s][i] = '0;
      errors = 0;
    endfunction

    function logic [W_BITS-1:0] word_of(int unsigned s, int unsigned i);
      if (s >= N_SETS || i >= lengths[s]) return '0;
      return words[s][i];
    endfunction

    function void shorten(int unsigned s);
      while (lengths[s] > 0 && word_of(s, lengths[s] - 1) == '0) lengths[s]--;
    endfunction

    function void note_request(bse_req_t q);
      bse_rsp_t r;
      int unsigned d, widx, bpos, top, n;
      logic [W_BITS-1:0] res[N_WORDS];
      logic [W_BITS-1:0] wa, wb, wc, wd, w;
      r = '0;
      d = q.dst_set;
      widx = q.bit_number / W_BITS;
      bpos = q.bit_number % W_BITS;
      if (d < N_SETS) begin
        case (q.operation)
          OP_SET: begin
            if (q.bit_number >= N_WORDS * W_BITS) begin
              r.status = 1'b1;
            end else begin
              for (int i = lengths[d]; i <= widx; i++) words[d][i] = '0;
              if (lengths[d] < widx + 1) lengths[d] = widx + 1;
              words[d][widx][bpos] = 1'b1;
            end
          end
          OP_CLEAR: begin
            if (widx < lengths[d]) begin
              words[d][widx][bpos] = 1'b0;
              shorten(d);
            end
          end
          OP_TEST: begin
            w = word_of(d, widx);
            r.bit_value = w[bpos];
          end
          OP_HIGH: begin
            if (lengths[d] > 0) begin
              top = lengths[d] - 1;
              w = word_of(d, top);
              n = 0;
              for (int k = 0; k < W_BITS; k++) if (w[k]) n = k + 1;
              r.highest_plus_one = HIGH_W'(top * W_BITS + n);
            end
          end
          OP_UNION, OP_INTER, OP_DIFF, OP_ORANDN: begin
            for (int i = 0; i < N_WORDS; i++) begin
              wa = word_of(q.src_a, i);
              wb = word_of(q.src_b, i);
              wc = word_of(q.src_c, i);
              wd = word_of(d, i);
              case (q.operation)
                OP_UNION: res[i] = wa | wb;
                OP_INTER: res[i] = wd & wb;
                OP_DIFF:  res[i] = wa & ~wb;
                default:  res[i] = wa | (wb & ~wc);
              endcase
              if (res[i] != wd) r.changed = 1'b1;
            end
            for (int i = 0; i < N_WORDS; i++) words[d][i] = res[i];
            lengths[d] = N_WORDS;
            shorten(d);
          end
          OP_EMPTY: lengths[d] = 0;
          default: ;
        endcase
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_response(bse_rsp_t got);
      bse_rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0b, expected %0b", got.status, want.status));
      if (got.bit_value !== want.bit_value)
        report($sformatf("bit_value %0b, expected %0b", got.bit_value, want.bit_value));
      if (got.highest_plus_one !== want.highest_plus_one)
        report($sformatf("highest_plus_one %0d, expected %0d",
                         got.highest_plus_one, want.highest_plus_one));
      if (got.changed !== want.changed)
        report($sformatf("changed %0b, expected %0b", got.changed, want.changed));
    endtask
  endclass
endpackage

// ----- tb/sv/bitset_store_engine_top_test.sv -----
`timescale 1ns / 1ps
module bitset_store_engine_top_test;
  import bse_pkg::*;
  import bse_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bse_in_if  in_chan ();
  bse_out_if out_chan ();
  bitset_scoreboard sb;
  bit hold_off = 1'b0;
  bit sent_all = 1'b0;

  bitset_store_engine_top dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always #5 clk = ~clk;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.operation = '0;
    in_chan.dst_set = '0;
    in_chan.src_a = '0;
    in_chan.src_b = '0;
    in_chan.src_c = '0;
    in_chan.bit_number = '0;
    out_chan.ready = 1'b0;
  end

  // Sends one item, holding valid until it is taken.
  task automatic send_item(bse_req_t q);
    in_chan.valid <= 1'b1;
    in_chan.operation <= q.operation;
    in_chan.dst_set <= q.dst_set;
    in_chan.src_a <= q.src_a;
    in_chan.src_b <= q.src_b;
    in_chan.src_c <= q.src_c;
    in_chan.bit_number <= q.bit_number;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic bse_req_t make_item(logic [3:0] op, int d, int n);
    bse_req_t q;
    q.operation = op;
    q.dst_set = SET_W'(d);
    q.src_a = SET_W'($urandom);
    q.src_b = SET_W'($urandom);
    q.src_c = SET_W'($urandom);
    q.bit_number = BITNUM_W'(n);
    return q;
  endfunction

  // Mostly bit edits and algebra; bit numbers cluster low so sets stay dense.
  function automatic bse_req_t random_item();
    bse_req_t q;
    int pick;
    q = make_item(OP_SET, $urandom_range(0, 7), 0);
    pick = $urandom_range(0, 99);
    if (pick < 30) q.operation = OP_SET;
    else if (pick < 42) q.operation = OP_CLEAR;
    else if (pick < 54) q.operation = OP_TEST;
    else if (pick < 62) q.operation = OP_HIGH;
    else if (pick < 90) q.operation = OP_W'($urandom_range(OP_UNION, OP_ORANDN));
    else if (pick < 95) q.operation = OP_EMPTY;
    else q.operation = OP_W'($urandom_range(9, 15));
    q.bit_number = ($urandom_range(0, 3) == 0) ? BITNUM_W'($urandom_range(0, 1023))
                                               : BITNUM_W'($urandom_range(0, 255));
    return q;
  endfunction

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int stall;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_chan.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = $urandom_range(0, 3);
      if (stall == 0) out_chan.ready <= 1'b0;
      else out_chan.ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_response({out_chan.status, out_chan.bit_value,
                         out_chan.highest_plus_one, out_chan.changed});
  end

  initial begin
    bse_req_t q;
    int burst;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, every operation and the special cases.
    send_item(make_item(OP_TEST, 0, 1023));
    send_item(make_item(OP_HIGH, 7, 0));
    send_item(make_item(OP_SET, 0, 0));
    send_item(make_item(OP_SET, 0, 1023));
    send_item(make_item(OP_SET, 1, 700));
    send_item(make_item(OP_HIGH, 0, 0));
    send_item(make_item(OP_TEST, 0, 1023));
    send_item(make_item(OP_TEST, 1, 5));
    send_item(make_item(OP_CLEAR, 0, 1023));
    send_item(make_item(OP_HIGH, 0, 0));
    send_item(make_item(OP_CLEAR, 2, 900));
    send_item(make_item(OP_SET, 2, 63));
    send_item(make_item(OP_SET, 2, 64));
    q = make_item(OP_UNION, 3, 0); q.src_a = 3'd0; q.src_b = 3'd1; send_item(q);
    q = make_item(OP_INTER, 3, 0); q.src_b = 3'd2; send_item(q);
    q = make_item(OP_DIFF, 4, 0); q.src_a = 3'd3; q.src_b = 3'd3; send_item(q);
    q = make_item(OP_ORANDN, 5, 0); q.src_a = 3'd2; q.src_b = 3'd1; q.src_c = 3'd7;
    send_item(q);
    q = make_item(OP_UNION, 5, 0); q.src_a = 3'd5; q.src_b = 3'd5; send_item(q);
    send_item(make_item(OP_HIGH, 5, 0));
    send_item(make_item(OP_EMPTY, 5, 0));
    send_item(make_item(OP_HIGH, 5, 0));
    send_item(make_item(4'd9, 1, 3));
    send_item(make_item(4'd15, 7, 1023));
    send_item(make_item(OP_SET, 7, 1023));
    pause_sender(2);

    // The receiver holds off while the sender keeps offering items.
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_item(random_item());

    // Random bursts with random pauses; one wait in the middle lets the block drain.
    for (int i = 0; i < 400; ) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++) begin
        send_item(random_item());
        i++;
      end
      if (i >= 200 && i < 200 + burst) begin
        in_chan.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 40));
      end
    end
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
